/* design/pmtc_pkg.sv */
// shared types, codes and the permission class lookup for the message type checker
package pmtc_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_TAG      = 3'd0,
    PH_SKIPVAR  = 3'd1,
    PH_LENVAR   = 3'd2,
    PH_SKIPBYTE = 3'd3,
    PH_TYPEVAR  = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  // running verdict of the parser
  typedef enum logic [1:0] {
    VS_NONE  = 2'd0,
    VS_FOUND = 2'd1,
    VS_BAD   = 2'd2
  } vstate_t;

  // reported parse status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // wire types that can be skipped
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // permission classes
  localparam logic [2:0] CLS_VIEW      = 3'd0;
  localparam logic [2:0] CLS_INPUT     = 3'd1;
  localparam logic [2:0] CLS_CLIPBOARD = 3'd2;
  localparam logic [2:0] CLS_FILE      = 3'd3;
  localparam logic [2:0] CLS_AUDIO     = 3'd4;

  localparam logic [31:0] TYPE_FIELD       = 32'd10;
  localparam logic [3:0]  VARINT_MAX_BYTES = 4'd10;
  localparam logic [63:0] FIXED64_BYTES    = 64'd8;
  localparam logic [63:0] FIXED32_BYTES    = 64'd4;

  // one finished payload, from parser to output stage
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] mtype;
  } verdict_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // message type to permission class
  function automatic logic [2:0] class_of(input logic [63:0] t);
    logic [2:0] c;
    case (t) inside
      64'd50, 64'd60, 64'd80, 64'd330, 64'd580:  c = CLS_INPUT;
      64'd160, 64'd161, [64'd349:64'd351], 64'd360: c = CLS_CLIPBOARD;
      64'd270, 64'd280:                         c = CLS_FILE;
      [64'd590:64'd593]:                        c = CLS_AUDIO;
      default:                                  c = CLS_VIEW;
    endcase
    return c;
  endfunction

endpackage

/* design/protobuf_message_type_permission_check.sv */
// Protobuf message type permission checker: payload bytes in, one verdict per payload out.
// One byte accepted every cycle unless full; the parser updates its varint or skip count per byte.
// Verdicts are queued at the last byte and move to the result register once it is empty or popped.
// Full rises only when QUEUE_DEPTH verdicts wait in the queue behind an unpopped result.
// Reset (rst, synchronous): parser to tag phase, queue and output emptied, permission mask 0.
module protobuf_message_type_permission_check #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic        authorized,
  output logic [1:0]  parse_status,
  output logic [63:0] msg_type,
  output logic [2:0]  permission_class,
  input  logic        permission_mask_write,
  input  logic [4:0]  permission_mask
);
  import pmtc_pkg::*;

  logic     take;
  verdict_t verdict, head;
  logic     verdict_valid;
  q_stat_t  qstat;
  logic     q_pop;

  // request acceptance
  assign full = qstat.full;
  assign take = push & ~qstat.full;

  // parser front
  pmtc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .payload_byte  (payload_byte),
    .last_byte     (last_byte),
    .take          (take),
    .verdict       (verdict),
    .verdict_valid (verdict_valid)
  );

  // verdict queue
  pmtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (verdict_valid),
    .wr_data (verdict),
    .rd      (q_pop),
    .rd_data (head),
    .stat    (qstat)
  );

  // result back end
  pmtc_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .head                  (head),
    .q_empty               (qstat.empty),
    .q_pop                 (q_pop),
    .permission_mask_write (permission_mask_write),
    .permission_mask       (permission_mask),
    .pop                   (pop),
    .empty                 (empty),
    .authorized            (authorized),
    .parse_status          (parse_status),
    .msg_type              (msg_type),
    .permission_class      (permission_class)
  );

  // a result without a found type carries no type, class or grant
  a_no_type_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && parse_status != ST_FOUND) |->
      (!authorized && msg_type == 64'd0 && permission_class == CLS_VIEW))
    else $error("result without type carries type fields");

  // a full queue that is not drained stays full
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (qstat.full && !q_pop) |=> qstat.full)
    else $error("queue lost an entry while full");

  // a payload end always leaves a verdict in the queue
  a_verdict_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_byte) |=> !qstat.empty)
    else $error("payload end produced no verdict");

endmodule

/* design/pmtc_front.sv */
// byte-wide wire format parser that produces one verdict per payload
module pmtc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         payload_byte,
  input  logic               last_byte,
  input  logic               take,
  output pmtc_pkg::verdict_t verdict,
  output logic               verdict_valid
);
  import pmtc_pkg::*;

  phase_t      phase, phase_next;
  vstate_t     vs, vs_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic [63:0] skip, skip_next;
  logic [63:0] found, found_next;

  logic [5:0]  shamt;
  logic [63:0] acc_sum;
  logic [3:0]  cnt_inc;
  logic [31:0] field;
  logic [2:0]  wt;

  // varint accumulation for the current byte
  assign shamt   = {2'b00, cnt} * 6'd7;
  assign acc_sum = acc | ({57'd0, payload_byte[6:0]} << shamt);
  assign cnt_inc = cnt + 4'd1;
  assign field   = acc_sum[34:3];
  assign wt      = acc_sum[2:0];

  // next state of the parser
  always_comb begin
    phase_next = phase;
    vs_next    = vs;
    acc_next   = acc;
    cnt_next   = cnt;
    skip_next  = skip;
    found_next = found;
    case (phase)
      PH_TAG, PH_SKIPVAR, PH_LENVAR, PH_TYPEVAR: begin
        acc_next = acc_sum;
        if (payload_byte[7]) begin
          if (cnt_inc >= VARINT_MAX_BYTES) begin
            cnt_next   = 4'd0;
            vs_next    = VS_BAD;
            phase_next = PH_DONE;
          end else begin
            cnt_next = cnt_inc;
          end
        end else begin
          acc_next = 64'd0;
          cnt_next = 4'd0;
          case (phase)
            PH_TAG: begin
              if (acc_sum == 64'd0) begin
                vs_next    = VS_BAD;
                phase_next = PH_DONE;
              end else if (field == TYPE_FIELD) begin
                if (wt != WT_VARINT) begin
                  vs_next    = VS_BAD;
                  phase_next = PH_DONE;
                end else begin
                  phase_next = PH_TYPEVAR;
                end
              end else begin
                case (wt)
                  WT_VARINT: phase_next = PH_SKIPVAR;
                  WT_FIXED64: begin
                    skip_next  = FIXED64_BYTES;
                    phase_next = PH_SKIPBYTE;
                  end
                  WT_LEN: phase_next = PH_LENVAR;
                  WT_FIXED32: begin
                    skip_next  = FIXED32_BYTES;
                    phase_next = PH_SKIPBYTE;
                  end
                  default: begin
                    vs_next    = VS_BAD;
                    phase_next = PH_DONE;
                  end
                endcase
              end
            end
            PH_SKIPVAR: phase_next = PH_TAG;
            PH_LENVAR: begin
              skip_next  = acc_sum;
              phase_next = (acc_sum == 64'd0) ? PH_TAG : PH_SKIPBYTE;
            end
            default: begin
              found_next = acc_sum;
              vs_next    = VS_FOUND;
              phase_next = PH_DONE;
            end
          endcase
        end
      end
      PH_SKIPBYTE: begin
        skip_next = skip - 64'd1;
        if (skip == 64'd1) begin
          phase_next = PH_TAG;
        end
      end
      default: ;
    endcase
  end

  // verdict for a payload that ends on this byte
  always_comb begin
    verdict_valid = take & last_byte;
    verdict.mtype = 64'd0;
    if (vs_next == VS_FOUND) begin
      verdict.status = ST_FOUND;
      verdict.mtype  = found_next;
    end else if (vs_next == VS_BAD || phase_next != PH_TAG) begin
      verdict.status = ST_BAD;
    end else begin
      verdict.status = ST_ABSENT;
    end
  end

  // parser registers, cleared at every payload end
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase <= PH_TAG;
      vs    <= VS_NONE;
      acc   <= 64'd0;
      cnt   <= 4'd0;
      skip  <= 64'd0;
      found <= 64'd0;
    end else if (take) begin
      phase <= phase_next;
      vs    <= vs_next;
      acc   <= acc_next;
      cnt   <= cnt_next;
      skip  <= skip_next;
      found <= found_next;
    end
  end

endmodule

/* design/pmtc_queue.sv */
// short verdict queue between the parser and the output stage
module pmtc_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  pmtc_pkg::verdict_t wr_data,
  input  logic               rd,
  output pmtc_pkg::verdict_t rd_data,
  output pmtc_pkg::q_stat_t  stat
);
  import pmtc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  verdict_t        entry [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign stat.empty = (count == CW'(0));
  assign stat.full  = (count == CW'(DEPTH));
  assign do_wr      = wr & ~stat.full;
  assign do_rd      = rd & ~stat.empty;
  assign rd_data    = entry[rd_ptr];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

/* design/pmtc_back.sv */
// class lookup, permission check and result register
module pmtc_back (
  input  logic               clk,
  input  logic               rst,
  input  pmtc_pkg::verdict_t head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               permission_mask_write,
  input  logic [4:0]         permission_mask,
  input  logic               pop,
  output logic               empty,
  output logic               authorized,
  output logic [1:0]         parse_status,
  output logic [63:0]        msg_type,
  output logic [2:0]         permission_class
);
  import pmtc_pkg::*;

  logic       out_valid;
  logic       load;
  logic [4:0] mask;
  logic [2:0] cls;

  assign load  = ~q_empty & (~out_valid | pop);
  assign q_pop = load;
  assign empty = ~out_valid;
  assign cls   = class_of(head.mtype);

  // granted class register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 5'd0;
    end else if (permission_mask_write) begin
      mask <= permission_mask;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      parse_status     <= head.status;
      msg_type         <= head.mtype;
      permission_class <= cls;
      authorized       <= (head.status == ST_FOUND) & mask[cls];
    end
  end

endmodule

/* verif/protobuf_message_type_permission_check_tb.sv */
`timescale 1ns / 100ps
// testbench for the protobuf message type checker: directed and random payloads vs a byte predictor
module testbench;
  import pmtc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RESET_CYCLES    = 9;
  localparam int QUIET_CYCLES    = 8;
  localparam int BYTES_PER_PHASE = 585;
  localparam int N_DIR           = 14;

  // one verdict as seen on the result ports
  typedef struct packed {
    logic        auth;
    logic [1:0]  status;
    logic [63:0] mtype;
    logic [2:0]  cls;
  } check_result_t;

  // one directed row: a mask write or a whole payload, first byte in the top used byte
  typedef struct packed {
    logic          cfg;
    logic [4:0]    mask;
    logic [4:0]    len;
    logic [127:0]  data;
    logic          known;
    check_result_t exp;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic        empty;
  logic        pop;
  logic        authorized;
  logic [1:0]  parse_status;
  logic [63:0] msg_type;
  logic [2:0]  permission_class;
  logic        permission_mask_write;
  logic [4:0]  permission_mask;

  // typed-in verdict that travels with a directed request
  logic          dir_known;
  check_result_t dir_exp;

  // predictor state
  phase_t      scan_phase;
  logic [63:0] var_acc;
  logic [3:0]  var_cnt;
  logic [2:0]  tag_wt;
  logic [63:0] skip_left;
  vstate_t     scan_verdict;
  logic [63:0] type_seen;
  logic [4:0]  granted;

  check_result_t verdicts_due[$];
  logic [7:0]    pend[$];
  stim_row_t     dir_tab [N_DIR];
  int            n_err;
  int            cycles;
  int            send_idle_pct;
  int            recv_idle_pct;

  protobuf_message_type_permission_check dut (
    .clk                   (clk),
    .rst                   (rst),
    .push                  (push),
    .full                  (full),
    .payload_byte          (payload_byte),
    .last_byte             (last_byte),
    .empty                 (empty),
    .pop                   (pop),
    .authorized            (authorized),
    .parse_status          (parse_status),
    .msg_type              (msg_type),
    .permission_class      (permission_class),
    .permission_mask_write (permission_mask_write),
    .permission_mask       (permission_mask)
  );

  always #5 clk = ~clk;

  // predictor: parse state back to a fresh payload
  function automatic void clear_scan();
    scan_phase   = PH_TAG;
    var_acc      = '0;
    var_cnt      = '0;
    tag_wt       = '0;
    skip_left    = '0;
    scan_verdict = VS_NONE;
    type_seen    = '0;
  endfunction

  function automatic void scan_fail();
    scan_verdict = VS_BAD;
    scan_phase   = PH_DONE;
  endfunction

  // message type to permission class
  function automatic logic [2:0] class_for(input logic [63:0] t);
    if (t == 64'd50 || t == 64'd60 || t == 64'd80 || t == 64'd330 || t == 64'd580)
      return CLS_INPUT;
    if (t == 64'd160 || t == 64'd161 || (t >= 64'd349 && t <= 64'd351) || t == 64'd360)
      return CLS_CLIPBOARD;
    if (t == 64'd270 || t == 64'd280)
      return CLS_FILE;
    if (t >= 64'd590 && t <= 64'd593)
      return CLS_AUDIO;
    return CLS_VIEW;
  endfunction

  // advance the field walk by one payload byte
  function automatic void scan_byte(input logic [7:0] b);
    logic [63:0] v;
    logic [31:0] fld;
    if (scan_phase == PH_DONE)
      return;
    if (scan_phase == PH_SKIPBYTE) begin
      skip_left = skip_left - 64'd1;
      if (skip_left == 64'd0)
        scan_phase = PH_TAG;
      return;
    end
    // varint byte: tenth byte only reaches bit 63
    var_acc = var_acc | (64'(b[6:0]) << (7 * var_cnt));
    if (b[7]) begin
      var_cnt = var_cnt + 4'd1;
      if (var_cnt == VARINT_MAX_BYTES) begin
        var_cnt = '0;
        scan_fail();
      end
      return;
    end
    var_cnt = '0;
    v       = var_acc;
    var_acc = '0;
    case (scan_phase)
      PH_TAG: begin
        fld = v[34:3];
        if (v == 64'd0) begin
          scan_fail();
        end else begin
          tag_wt = v[2:0];
          if (fld == TYPE_FIELD) begin
            if (tag_wt != WT_VARINT)
              scan_fail();
            else
              scan_phase = PH_TYPEVAR;
          end else begin
            case (tag_wt)
              WT_VARINT: scan_phase = PH_SKIPVAR;
              WT_FIXED64: begin
                skip_left  = FIXED64_BYTES;
                scan_phase = PH_SKIPBYTE;
              end
              WT_LEN: scan_phase = PH_LENVAR;
              WT_FIXED32: begin
                skip_left  = FIXED32_BYTES;
                scan_phase = PH_SKIPBYTE;
              end
              default: scan_fail();
            endcase
          end
        end
      end
      PH_SKIPVAR: scan_phase = PH_TAG;
      PH_LENVAR: begin
        skip_left  = v;
        scan_phase = (v == 64'd0) ? PH_TAG : PH_SKIPBYTE;
      end
      default: begin
        type_seen    = v;
        scan_verdict = VS_FOUND;
        scan_phase   = PH_DONE;
      end
    endcase
  endfunction

  // verdict at the last byte, then start over
  function automatic check_result_t close_payload();
    check_result_t r;
    r = '0;
    if (scan_verdict == VS_FOUND) begin
      r.status = ST_FOUND;
      r.mtype  = type_seen;
      r.cls    = class_for(type_seen);
      r.auth   = granted[r.cls];
    end else if (scan_verdict == VS_BAD || scan_phase != PH_TAG) begin
      r.status = ST_BAD;
    end else begin
      r.status = ST_ABSENT;
    end
    clear_scan();
    return r;
  endfunction

  function automatic check_result_t make_result(input logic [1:0] st, input logic [63:0] mt,
                                                input logic [2:0] cls, input logic auth);
    check_result_t r;
    r.auth   = auth;
    r.status = st;
    r.mtype  = mt;
    r.cls    = cls;
    return r;
  endfunction

  function automatic stim_row_t row_bytes(input int len, input logic [127:0] data,
                                          input logic known, input check_result_t exp);
    stim_row_t r;
    r       = '0;
    r.len   = 5'(len);
    r.data  = data;
    r.known = known;
    r.exp   = exp;
    return r;
  endfunction

  function automatic stim_row_t row_mask(input logic [4:0] m);
    stim_row_t r;
    r      = '0;
    r.cfg  = 1'b1;
    r.mask = m;
    return r;
  endfunction

  // random helpers for payload building
  function automatic logic [63:0] rand_width_val();
    int          w;
    logic [63:0] v;
    w = $urandom_range(1, 64);
    v = {$urandom, $urandom};
    if (w < 64)
      v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  function automatic int rand_pad();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 9)) : 0;
  endfunction

  function automatic logic [28:0] tag_junk();
    return ($urandom_range(0, 9) == 0) ? 29'($urandom) : 29'd0;
  endfunction

  // class members and their neighbors
  function automatic logic [63:0] known_type();
    case ($urandom_range(0, 23))
      0:  return 64'd50;
      1:  return 64'd60;
      2:  return 64'd80;
      3:  return 64'd330;
      4:  return 64'd580;
      5:  return 64'd160;
      6:  return 64'd161;
      7:  return 64'd349;
      8:  return 64'd350;
      9:  return 64'd351;
      10: return 64'd360;
      11: return 64'd270;
      12: return 64'd280;
      13: return 64'd590;
      14: return 64'd591;
      15: return 64'd592;
      16: return 64'd593;
      17: return 64'd589;
      18: return 64'd594;
      19: return 64'd348;
      20: return 64'd352;
      21: return 64'd0;
      22: return 64'd1;
      default: return 64'd581;
    endcase
  endfunction

  // varint, optionally padded with redundant continuation bytes
  task automatic put_varint(input logic [63:0] v, input int pad);
    int          n;
    int          k;
    logic [63:0] t;
    logic [6:0]  chunk;
    n = 1;
    t = v >> 7;
    while (t != 64'd0) begin
      n++;
      t = t >> 7;
    end
    k = (n + pad > 10) ? 10 : n + pad;
    for (int i = 0; i < k; i++) begin
      chunk = 7'(v >> (7 * i));
      if (i == 9)
        chunk = {6'($urandom), v[63]};
      pend.push_back({(i < k - 1), chunk});
    end
  endtask

  // one payload: noise, well-formed fields, or a truncated well-formed one
  task automatic gen_payload();
    int          kind;
    int          nf;
    int          nb;
    logic        has_type;
    logic [31:0] fld;
    logic [2:0]  wt;
    logic [63:0] len;
    pend.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12)) pend.push_back(8'($urandom));
    end else begin
      has_type = ($urandom_range(0, 99) < 85);
      nf = $urandom_range(has_type ? 0 : 1, 3);
      // skippable fields ahead of the type
      repeat (nf) begin
        fld = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(1, 15)) : 32'($urandom);
        if (fld == TYPE_FIELD)
          fld = fld + 32'd1;
        case ($urandom_range(0, 3))
          0:       wt = WT_VARINT;
          1:       wt = WT_FIXED64;
          2:       wt = WT_LEN;
          default: wt = WT_FIXED32;
        endcase
        put_varint({tag_junk(), fld, wt}, rand_pad());
        case (wt)
          WT_VARINT:  put_varint(rand_width_val(), rand_pad());
          WT_FIXED64: repeat (8) pend.push_back(8'($urandom));
          WT_FIXED32: repeat (4) pend.push_back(8'($urandom));
          default: begin
            len = ($urandom_range(0, 19) == 0) ? rand_width_val()
                                               : 64'($urandom_range(0, 6));
            put_varint(len, rand_pad());
            nb = (len > 64'd6) ? 3 : int'(len);
            repeat (nb) pend.push_back(8'($urandom));
          end
        endcase
      end
      // type field, now and then with a wrong wire type, then trailing bytes
      if (has_type) begin
        wt = ($urandom_range(0, 9) == 0) ? 3'($urandom) : WT_VARINT;
        put_varint({tag_junk(), TYPE_FIELD, wt}, rand_pad());
        put_varint(($urandom_range(0, 1) == 1) ? known_type() : rand_width_val(), rand_pad());
        if ($urandom_range(0, 9) < 3)
          repeat ($urandom_range(1, 4)) pend.push_back(8'($urandom));
      end
      if (kind < 24) begin
        nb = $urandom_range(1, pend.size());
        while (pend.size() > nb)
          pend.delete(pend.size() - 1);
      end
    end
  endtask

  // offer one request, idling at random first
  task automatic send_byte(input logic [7:0] b, input logic last, input logic known,
                           input check_result_t exp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push         <= 1'b0;
      payload_byte <= 8'($urandom);
      last_byte    <= 1'($urandom);
      dir_known    <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    payload_byte <= b;
    last_byte    <= last;
    dir_known    <= known;
    dir_exp      <= exp;
    @(posedge clk);
    while (full)
      @(posedge clk);
  endtask

  // stop sending, wait for every verdict, then let the pipeline go quiet
  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (verdicts_due.size() != 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [4:0] m);
    permission_mask_write <= 1'b1;
    permission_mask       <= m;
    @(posedge clk);
    permission_mask_write <= 1'b0;
  endtask

  // receiver: random pop
  always @(posedge clk)
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);

  // cycle limit
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // check popped verdicts, track mask writes, predict on accepted requests
  always @(posedge clk) begin : monitor
    check_result_t want;
    check_result_t pred;
    if (!rst) begin
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          $error("result with no request pending");
          n_err++;
        end else begin
          want = verdicts_due.pop_front();
          if (authorized !== want.auth) begin
            $error("authorized: expected %0d, got %0d", want.auth, authorized);
            n_err++;
          end
          if (parse_status !== want.status) begin
            $error("parse_status: expected %0d, got %0d", want.status, parse_status);
            n_err++;
          end
          if (msg_type !== want.mtype) begin
            $error("msg_type: expected %h, got %h", want.mtype, msg_type);
            n_err++;
          end
          if (permission_class !== want.cls) begin
            $error("permission_class: expected %0d, got %0d", want.cls, permission_class);
            n_err++;
          end
        end
      end
      if (permission_mask_write)
        granted = permission_mask;
      if (push && !full) begin
        scan_byte(payload_byte);
        if (last_byte) begin
          pred = close_payload();
          verdicts_due.push_back(dir_known ? dir_exp : pred);
        end
      end
    end
  end

  initial begin
    int   sent;
    logic pressed;
    clk                   = 1'b0;
    cycles                = 0;
    n_err                 = 0;
    rst                   <= 1'b1;
    push                  <= 1'b0;
    payload_byte          <= '0;
    last_byte             <= 1'b0;
    pop                   <= 1'b0;
    permission_mask_write <= 1'b0;
    permission_mask       <= '0;
    dir_known             <= 1'b0;
    dir_exp               <= '0;
    clear_scan();
    granted       = '0;
    send_idle_pct = 32;
    recv_idle_pct = 81;

    // directed rows
    dir_tab[0]  = row_bytes(2, 128'h5032, 1'b1,
                            make_result(ST_FOUND, 64'd50, CLS_INPUT, 1'b0));
    dir_tab[1]  = row_mask(5'h1f);
    // zero tag
    dir_tab[2]  = row_bytes(1, 128'h00, 1'b1, make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    // wire types 3, 4, 6, 7
    dir_tab[3]  = row_bytes(1, 128'h0b, 1'b1, make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    dir_tab[4]  = row_bytes(1, 128'h0c, 1'b1, make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    dir_tab[5]  = row_bytes(1, 128'h0e, 1'b1, make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    dir_tab[6]  = row_bytes(1, 128'h0f, 1'b1, make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    // type field as length-delimited
    dir_tab[7]  = row_bytes(1, 128'h52, 1'b1, make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    // tag with no body
    dir_tab[8]  = row_bytes(1, 128'h08, 1'b1, make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    // empty length-delimited field, clean end, no type
    dir_tab[9]  = row_bytes(2, 128'h0a00, 1'b1,
                            make_result(ST_ABSENT, 64'd0, CLS_VIEW, 1'b0));
    // over-long varint
    dir_tab[10] = row_bytes(10, 128'hffffffffffffffffffff, 1'b1,
                            make_result(ST_BAD, 64'd0, CLS_VIEW, 1'b0));
    // largest type, then a byte after the verdict
    dir_tab[11] = row_bytes(12, 128'h50ffffffffffffffffff0100, 1'b1,
                            make_result(ST_FOUND, '1, CLS_VIEW, 1'b1));
    dir_tab[12] = row_mask(5'h15);
    // skipped length-delimited field, then a clipboard type
    dir_tab[13] = row_bytes(7, 128'h1202aabb50a001, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].cfg) begin
        settle();
        write_mask(dir_tab[i].mask);
      end else begin
        for (int k = int'(dir_tab[i].len) - 1; k >= 0; k--)
          send_byte(dir_tab[i].data[8 * k +: 8], k == 0, dir_tab[i].known, dir_tab[i].exp);
      end
    end

    // random part: three idling profiles, a new mask for each
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 81;
          write_mask(5'($urandom));
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 32;
          write_mask(5'h00);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_mask(5'h1f);
        end
      endcase
      sent    = 0;
      pressed = 1'b0;
      while (sent < BYTES_PER_PHASE) begin
        gen_payload();
        for (int j = 0; j < pend.size(); j++)
          send_byte(pend[j], j == pend.size() - 1, 1'b0, '0);
        sent += pend.size();
        // hold off once until the queue has drained
        if (!pressed && sent >= BYTES_PER_PHASE / 2) begin
          settle();
          pressed = 1'b1;
        end
      end
    end

    settle();
    if (n_err == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
